FILE: hw/rtl/irbw_pkg.sv
// Package for the interlaced raster beam writer.
// Holds the shared constants, colour codes and the result record type.
// Depends on nothing; every RTL file of the block refers to it by scoped names.
`default_nettype none

package irbw_pkg;

    // Default frame buffer geometry in pixels.
    localparam int DEFAULT_BUFFER_WIDTH  = 1024;
    localparam int DEFAULT_BUFFER_HEIGHT = 626;

    // Width of the byte address bus.
    localparam int ADDR_W  = 21;
    localparam int COLOR_W = 24;

    // Colours used outside the display area.
    localparam logic [COLOR_W-1:0] GREY_LEVEL = 24'h808080;
    localparam logic [COLOR_W-1:0] SYNC_RED   = 24'hff0000;
    localparam logic [COLOR_W-1:0] SYNC_GREEN = 24'h00ff00;

    // One pixel write as delivered on the result channel.
    typedef struct packed {
        logic              write_valid;
        logic [ADDR_W-1:0] write_address;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic              frame_done;
    } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/interlaced_raster_beam_writer.sv
// Top level of the interlaced raster beam writer: input register, beam core, result register.
// Depends on irbw_pkg and irbw_beam_core.
//
// Takes one pixel tick per transaction from an interlaced video timing source and
// produces one result per tick: a frame buffer write (byte address of the red byte
// and the RGB bytes) when the beam lies inside the BUFFER_WIDTH x BUFFER_HEIGHT
// buffer, and a frame_done flag on each falling vsync. The block sustains one
// transaction per clock cycle while m_ready stays high; a result passes through the
// input register and then the result register before it is presented. The row base
// address is kept as a running sum, so the address path is three chained adds with
// no multiplier.
`default_nettype none

module interlaced_raster_beam_writer #(
    parameter int BUFFER_WIDTH  = irbw_pkg::DEFAULT_BUFFER_WIDTH,
    parameter int BUFFER_HEIGHT = irbw_pkg::DEFAULT_BUFFER_HEIGHT
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_vsync,
    input  wire logic                        s_hsync,
    input  wire logic                        s_active_area,
    input  wire logic [23:0]                 s_pixel_rgb,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_write_valid,
    output logic [irbw_pkg::ADDR_W-1:0]      m_write_address,
    output logic [7:0]                       m_red,
    output logic [7:0]                       m_green,
    output logic [7:0]                       m_blue,
    output logic                             m_frame_done
);

    logic              in_valid_reg;
    logic              vs_reg, hs_reg, de_reg;
    logic [23:0]       rgb_reg;
    logic              out_valid_reg;
    irbw_pkg::result_t out_reg;
    irbw_pkg::result_t core_result;
    logic              advance, step;

    // The pipeline moves whenever the result register is free or being emptied.
    assign advance = !out_valid_reg || m_ready;
    assign step    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            vs_reg  <= s_vsync;
            hs_reg  <= s_hsync;
            de_reg  <= s_active_area;
            rgb_reg <= s_pixel_rgb;
        end
    end

    irbw_beam_core #(
        .BUFFER_WIDTH  (BUFFER_WIDTH),
        .BUFFER_HEIGHT (BUFFER_HEIGHT)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (step),
        .vsync          (vs_reg),
        .hsync          (hs_reg),
        .active_area    (de_reg),
        .pixel_rgb      (rgb_reg),
        .result         (core_result)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= core_result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_write_valid   = out_reg.write_valid;
    assign m_write_address = out_reg.write_address;
    assign m_red           = out_reg.red;
    assign m_green         = out_reg.green;
    assign m_blue          = out_reg.blue;
    assign m_frame_done    = out_reg.frame_done;

endmodule

`default_nettype wire

FILE: hw/rtl/irbw_beam_core.sv
// Beam position tracker and pixel write formatter of the interlaced raster beam writer.
// Holds the column, row, row base address, sync history and field flag.
// Depends on irbw_pkg.
`default_nettype none

module irbw_beam_core #(
    parameter int BUFFER_WIDTH  = irbw_pkg::DEFAULT_BUFFER_WIDTH,
    parameter int BUFFER_HEIGHT = irbw_pkg::DEFAULT_BUFFER_HEIGHT
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      step,
    input  wire logic                      vsync,
    input  wire logic                      hsync,
    input  wire logic                      active_area,
    input  wire logic [23:0]               pixel_rgb,
    output irbw_pkg::result_t              result
);

    localparam int COL_W  = $clog2(BUFFER_WIDTH + 1);
    localparam int ROW_W  = $clog2(BUFFER_HEIGHT + 1);
    localparam int ADDR_W = irbw_pkg::ADDR_W;

    localparam logic [COL_W-1:0]  COL_MAX   = COL_W'(BUFFER_WIDTH);
    localparam logic [ROW_W:0]    ROW_MAX_X = (ROW_W + 1)'(BUFFER_HEIGHT);
    localparam logic [ROW_W-1:0]  ROW_MAX   = ROW_W'(BUFFER_HEIGHT);
    localparam logic [ADDR_W-1:0] LINE_STEP = ADDR_W'(BUFFER_WIDTH);
    localparam logic [ADDR_W-1:0] PAIR_STEP = ADDR_W'(2 * BUFFER_WIDTH);

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic              phs_reg, pvs_reg, even_reg, even_next;

    logic              h_fall, v_fall;
    logic [ROW_W:0]    row_plus2;
    logic [ADDR_W-1:0] pix_index, byte_addr;
    logic              in_buffer;
    logic [23:0]       color;

    // Edge handling: hsync first, then a vsync edge overrides the row, and the column in the even field.
    always_comb begin
        h_fall    = !hsync && phs_reg;
        v_fall    = !vsync && pvs_reg;
        row_plus2 = {1'b0, row_reg} + (ROW_W + 1)'(2);
        col_next  = col_reg;
        row_next  = row_reg;
        base_next = base_reg;
        even_next = even_reg;
        if (h_fall) begin
            col_next  = '0;
            row_next  = (row_plus2 >= ROW_MAX_X) ? ROW_MAX : row_plus2[ROW_W-1:0];
            base_next = base_reg + PAIR_STEP;
        end
        if (v_fall) begin
            if (even_reg) begin
                col_next  = '0;
                row_next  = ROW_W'(1);
                base_next = LINE_STEP;
            end else begin
                row_next  = '0;
                base_next = '0;
            end
            even_next = !even_reg;
        end
    end

    // Pixel write for the beam position after the edges.
    always_comb begin
        in_buffer = (col_next < COL_MAX) && (row_next < ROW_MAX);
        pix_index = base_next + ADDR_W'(col_next);
        byte_addr = pix_index + {pix_index[ADDR_W-2:0], 1'b0};
        if (active_area) begin
            color = pixel_rgb;
        end else begin
            color = irbw_pkg::GREY_LEVEL
                  | (vsync ? irbw_pkg::SYNC_RED : '0)
                  | (hsync ? irbw_pkg::SYNC_GREEN : '0);
        end
        result.write_valid   = in_buffer;
        result.write_address = in_buffer ? byte_addr : '0;
        result.red           = in_buffer ? color[23:16] : '0;
        result.green         = in_buffer ? color[15:8] : '0;
        result.blue          = in_buffer ? color[7:0] : '0;
        result.frame_done    = v_fall;
    end

    // Beam state advances once per transaction; the column saturates at the buffer edge.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            base_reg <= '0;
            phs_reg  <= 1'b0;
            pvs_reg  <= 1'b0;
            even_reg <= 1'b1;
        end else if (step) begin
            col_reg  <= (col_next < COL_MAX) ? col_next + COL_W'(1) : col_next;
            row_reg  <= row_next;
            base_reg <= base_next;
            phs_reg  <= hsync;
            pvs_reg  <= vsync;
            even_reg <= even_next;
        end
    end

    // The beam never passes the saturation points.
    a_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= COL_MAX)
        else $error("beam column beyond buffer width");

    a_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        row_reg <= ROW_MAX)
        else $error("beam row beyond buffer height");

    // The running row base must track row times width while the row is in the buffer.
    a_base_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (row_reg < ROW_MAX) |->
            (base_reg == ADDR_W'(32'(row_reg) * 32'(BUFFER_WIDTH))))
        else $error("row base address out of step with beam row");

    // A field end flips the field flag and nothing else does.
    a_field_flip: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> (even_reg != $past(even_reg)) == $past(v_fall))
        else $error("field flag changed without a falling vsync");

endmodule

`default_nettype wire

FILE: tb/sv/tb_interlaced_raster_beam_writer.sv
`timescale 1ns / 1ps
// Self-checking testbench for interlaced_raster_beam_writer at its default buffer geometry.
// Depends on irbw_pkg and the block's RTL; predicts every pixel write and checks it in order.

module tb_interlaced_raster_beam_writer;

    localparam int unsigned BEAM_W         = irbw_pkg::DEFAULT_BUFFER_WIDTH;
    localparam int unsigned BEAM_H         = irbw_pkg::DEFAULT_BUFFER_HEIGHT;
    localparam int unsigned MAX_CYCLES     = 200000;
    localparam int unsigned HOLDOFF_CYCLES = 300;
    localparam int unsigned MAX_PRINTED    = 20;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic                        s_vsync;
    logic                        s_hsync;
    logic                        s_active_area;
    logic [23:0]                 s_pixel_rgb;
    logic                        m_valid;
    logic                        m_ready;
    logic                        m_write_valid;
    logic [irbw_pkg::ADDR_W-1:0] m_write_address;
    logic [7:0]                  m_red;
    logic [7:0]                  m_green;
    logic [7:0]                  m_blue;
    logic                        m_frame_done;

    int unsigned sender_idle_pct;
    int unsigned stall_pct;
    int unsigned holdoff_requests;
    int unsigned items_sent;
    int unsigned cycle_count;

    // Tracks the beam position and field, and holds the writes still owed by the block.
    class beam_write_scoreboard;
        int unsigned        beam_x;
        int unsigned        beam_y;
        bit                 hs_last;
        bit                 vs_last;
        bit                 field_is_even;
        irbw_pkg::result_t  expected_writes[$];
        int unsigned        mismatches;
        int unsigned        results_checked;
        int unsigned        fields_closed;
        int unsigned        writes_outside;

        function new();
            beam_x        = 0;
            beam_y        = 0;
            hs_last       = 1'b0;
            vs_last       = 1'b0;
            field_is_even = 1'b1;
        endfunction

        // Advances the beam for one accepted pixel transaction and queues its write.
        function void predict_pixel(bit vs, bit hs, bit de, logic [23:0] rgb);
            irbw_pkg::result_t want;
            logic [23:0]       colour;
            logic [31:0]       full_addr;
            bit                in_buffer;

            want = '0;
            // A falling hsync starts the next line of this field, two rows down.
            if (!hs && hs_last) begin
                beam_x = 0;
                beam_y = (beam_y + 2 >= BEAM_H) ? BEAM_H : beam_y + 2;
            end
            // A falling vsync closes the field; it takes priority over the row move.
            if (!vs && vs_last) begin
                if (field_is_even) begin
                    beam_x = 0;
                end
                beam_y          = field_is_even ? 1 : 0;
                field_is_even   = !field_is_even;
                want.frame_done = 1'b1;
                fields_closed++;
            end

            in_buffer = (beam_x < BEAM_W) && (beam_y < BEAM_H);
            if (in_buffer) begin
                if (de) begin
                    colour = rgb;
                end else begin
                    colour = irbw_pkg::GREY_LEVEL
                           | (vs ? irbw_pkg::SYNC_RED : 24'h0)
                           | (hs ? irbw_pkg::SYNC_GREEN : 24'h0);
                end
                full_addr          = (beam_y * BEAM_W + beam_x) * 3;
                want.write_valid   = 1'b1;
                want.write_address = full_addr[irbw_pkg::ADDR_W-1:0];
                want.red           = colour[23:16];
                want.green         = colour[15:8];
                want.blue          = colour[7:0];
            end else begin
                writes_outside++;
            end
            expected_writes.push_back(want);

            hs_last = hs;
            vs_last = vs;
            if (beam_x < BEAM_W) begin
                beam_x++;
            end
        endfunction

        task report_mismatch(string what, longint unsigned got_v, longint unsigned want_v);
            mismatches++;
            if (mismatches <= MAX_PRINTED) begin
                $display("MISMATCH %s at result %0d: got 0x%0h, expected 0x%0h",
                         what, results_checked, got_v, want_v);
            end
        endtask

        // Compares one result transaction with the oldest pending write.
        task check_write(irbw_pkg::result_t got);
            irbw_pkg::result_t want;
            if (expected_writes.size() == 0) begin
                report_mismatch("result with nothing pending", 1, 0);
                return;
            end
            want = expected_writes.pop_front();
            if (got.write_valid !== want.write_valid)
                report_mismatch("write_valid", got.write_valid, want.write_valid);
            if (got.write_address !== want.write_address)
                report_mismatch("write_address", got.write_address, want.write_address);
            if (got.red !== want.red)
                report_mismatch("red", got.red, want.red);
            if (got.green !== want.green)
                report_mismatch("green", got.green, want.green);
            if (got.blue !== want.blue)
                report_mismatch("blue", got.blue, want.blue);
            if (got.frame_done !== want.frame_done)
                report_mismatch("frame_done", got.frame_done, want.frame_done);
            results_checked++;
        endtask
    endclass

    beam_write_scoreboard write_sb;

    interlaced_raster_beam_writer dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_vsync          (s_vsync),
        .s_hsync          (s_hsync),
        .s_active_area    (s_active_area),
        .s_pixel_rgb      (s_pixel_rgb),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_write_valid    (m_write_valid),
        .m_write_address  (m_write_address),
        .m_red            (m_red),
        .m_green          (m_green),
        .m_blue           (m_blue),
        .m_frame_done     (m_frame_done)
    );

    // 8 ns clock.
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES) begin
            $display("Timeout after %0d cycles, %0d writes still pending",
                     cycle_count, write_sb.expected_writes.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Both channels are sampled at the rising edge; the input is noted before any result.
    always @(posedge aclk) begin : monitor
        irbw_pkg::result_t got;
        if (aresetn === 1'b1) begin
            if (s_valid && s_ready) begin
                write_sb.predict_pixel(s_vsync, s_hsync, s_active_area, s_pixel_rgb);
            end
            if (m_valid && m_ready) begin
                got.write_valid   = m_write_valid;
                got.write_address = m_write_address;
                got.red           = m_red;
                got.green         = m_green;
                got.blue          = m_blue;
                got.frame_done    = m_frame_done;
                write_sb.check_write(got);
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off whenever one is requested.
    initial begin : receiver
        int unsigned hold_left;
        int unsigned holdoffs_served;
        hold_left       = 0;
        holdoffs_served = 0;
        m_ready         = 1'b0;
        forever begin
            @(negedge aclk);
            if (holdoff_requests != holdoffs_served) begin
                holdoffs_served = holdoff_requests;
                hold_left       = HOLDOFF_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Offers one pixel transaction and returns at the edge where it is accepted.
    task automatic send_tick(input bit vs, input bit hs, input bit de, input logic [23:0] rgb);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_vsync       <= vs;
        s_hsync       <= hs;
        s_active_area <= de;
        s_pixel_rgb   <= rgb;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Drops valid and waits until every predicted write has come back.
    task automatic drain_writes();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (write_sb.expected_writes.size() != 0) @(posedge aclk);
    endtask

    // One scan line: an hsync pulse, then the visible pixels with hsync low.
    task automatic send_line(input int unsigned visible);
        repeat ($urandom_range(3, 1)) send_tick(1'b0, 1'b1, 1'b0, 24'($urandom));
        repeat (visible) send_tick(1'b0, 1'b0, ($urandom_range(99) < 90), 24'($urandom));
    endtask

    // A vsync pulse of a few ticks followed by its falling edge.
    task automatic send_vsync_pulse(input int unsigned width);
        repeat (width) send_tick(1'b1, 1'($urandom_range(1)), 1'b0, 24'($urandom));
        send_tick(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)), 24'($urandom));
    endtask

    // Edge cases right after reset: colours, sync edges, both fields.
    task automatic run_directed();
        send_tick(1'b0, 1'b0, 1'b1, 24'h000000);   // first pixel lands on address zero
        send_tick(1'b0, 1'b0, 1'b1, 24'hffffff);
        send_tick(1'b0, 1'b0, 1'b0, 24'h123456);   // blanking gives plain grey
        send_tick(1'b0, 1'b1, 1'b0, 24'hffffff);   // grey plus green
        send_tick(1'b1, 1'b1, 1'b0, 24'h000000);   // grey plus red and green
        send_tick(1'b1, 1'b0, 1'b0, 24'h000000);   // hsync falls: two rows down
        send_tick(1'b0, 1'b0, 1'b1, 24'haaaaaa);   // vsync falls in the even field
        send_tick(1'b0, 1'b0, 1'b1, 24'h555555);
        send_tick(1'b1, 1'b1, 1'b1, 24'hc3a5f0);
        send_tick(1'b0, 1'b0, 1'b1, 24'h0f5a3c);   // both syncs fall on one tick, odd field
        send_tick(1'b0, 1'b0, 1'b1, 24'h800001);
        send_tick(1'b1, 1'b0, 1'b1, 24'h7ffffe);
        send_tick(1'b0, 1'b0, 1'b1, 24'h010203);   // vsync alone, even field: column clears
        send_tick(1'b0, 1'b0, 1'b1, 24'hfefdfc);
        send_tick(1'b1, 1'b0, 1'b1, 24'h00ff00);
        send_tick(1'b0, 1'b0, 1'b1, 24'hff00ff);   // vsync alone, odd field: column runs on
        send_tick(1'b0, 1'b1, 1'b1, 24'h0000ff);   // display enable wins over sync colour
        send_tick(1'b1, 1'b1, 1'b1, 24'hff0000);
        send_tick(1'b0, 1'b0, 1'b0, 24'h000000);   // both fall together in the even field
    endtask

    // Mostly well-formed lines and fields with random content, some raw noise.
    task automatic run_traffic(input int unsigned count);
        int unsigned stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 15) begin
                repeat ($urandom_range(5, 1))
                    send_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
                              1'($urandom_range(1)), 24'($urandom));
            end else begin
                send_line($urandom_range(24, 1));
                if ($urandom_range(99) < 15) begin
                    send_vsync_pulse($urandom_range(3, 1));
                end
            end
        end
    endtask

    // Walks the beam off the right edge, then off the bottom of the buffer.
    task automatic run_saturation();
        send_line(BEAM_W + 6);
        send_vsync_pulse(2);
        repeat (BEAM_H / 2 + 4) begin
            send_tick(1'b0, 1'b1, 1'b0, 24'($urandom));
            send_tick(1'b0, 1'b0, 1'b1, 24'($urandom));
        end
        send_line(4);
        send_vsync_pulse(1);
        send_line(8);
    endtask

    initial begin
        write_sb         = new();
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_vsync          = 1'b0;
        s_hsync          = 1'b0;
        s_active_area    = 1'b0;
        s_pixel_rgb      = '0;
        sender_idle_pct  = 0;
        stall_pct        = 0;
        holdoff_requests = 0;
        items_sent       = 0;
        cycle_count      = 0;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Full rate on both sides.
        run_directed();
        run_saturation();
        run_traffic(130);

        // Sender idles about half the time.
        sender_idle_pct = 49;
        run_traffic(125);

        // Back pressure: the receiver holds off while the sender keeps offering.
        sender_idle_pct = 0;
        stall_pct       = 0;
        holdoff_requests++;
        run_traffic(60);
        drain_writes();

        // Receiver stalls about half the time.
        stall_pct = 49;
        run_traffic(125);

        // Light idling on both sides.
        sender_idle_pct = 11;
        stall_pct       = 11;
        run_traffic(125);

        drain_writes();
        repeat (10) @(posedge aclk);

        $display("Sent %0d pixel transactions, checked %0d writes in %0d cycles.",
                 items_sent, write_sb.results_checked, cycle_count);
        $display("Closed %0d fields; %0d ticks fell outside the buffer.",
                 write_sb.fields_closed, write_sb.writes_outside);
        if (write_sb.mismatches == 0 && write_sb.expected_writes.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
